// ===== hw/rtl/ljf_pkg.sv =====
// shared types and constants of the lennard-jones pair force accumulator
package ljf_pkg;

  // fixed-point format of positions and registers
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned DISP_W  = POS_W + 1;
  localparam int unsigned FORCE_W = 48;

  // internal number formats
  localparam int unsigned Q_FRAC      = 32;
  localparam int unsigned Q_LIMIT     = 46;
  localparam int unsigned Q_SHIFT     = Q_LIMIT - Q_FRAC;
  localparam int unsigned S6_FRAC     = 20;
  localparam int unsigned M_FRAC      = 16;
  localparam int unsigned SCALE_SHIFT = FRACTION_BITS + M_FRAC - S6_FRAC;
  localparam int unsigned M_W         = 63;
  localparam int unsigned M_LIM_SHIFT = M_W - SCALE_SHIFT;

  // datapath widths
  localparam int unsigned R2_W   = 68;
  localparam int unsigned QUO_W  = 63;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned MA_W   = 128;
  localparam int unsigned MB_W   = 64;
  localparam int unsigned ACC_W  = 192;

  // queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;

  // register map
  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_BOX     = 2'd0;
  localparam logic [1:0] REG_SIGMA   = 2'd1;
  localparam logic [1:0] REG_EPSILON = 2'd2;

  localparam logic [31:0] BOX_RESET     = 32'(10 << FRACTION_BITS);
  localparam logic [31:0] SIGMA_RESET   = 32'(1 << FRACTION_BITS);
  localparam logic [31:0] EPSILON_RESET = 32'(1 << FRACTION_BITS);

  typedef enum logic [1:0] {
    KIND_PAIR,
    KIND_SELF,
    KIND_ZERO
  } ljf_kind_e;

  typedef struct packed {
    logic [POS_W-1:0] ref_x;
    logic [POS_W-1:0] ref_y;
    logic [POS_W-1:0] ref_z;
    logic [POS_W-1:0] nb_x;
    logic [POS_W-1:0] nb_y;
    logic [POS_W-1:0] nb_z;
    logic             is_self;
    logic             last_neighbour;
  } ljf_in_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic signed [FORCE_W-1:0] force_z;
    logic                      zero_distance_seen;
    logic                      overflow_seen;
  } ljf_out_t;

  // classified pair waiting in the queue
  typedef struct packed {
    ljf_kind_e                  kind;
    logic                       last;
    logic [2:0][DISP_W-1:0]     d;
  } ljf_pair_t;

  typedef struct packed {
    logic            start;
    logic            keep;
    logic [1:0]      a_last;
    logic            b_last;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } ljf_mul_req_t;

  typedef struct packed {
    logic             start;
    logic [R2_W-1:0]  divisor;
    logic [R2_W-1:0]  rem_init;
    logic [QUO_W-1:0] bits;
    logic [CNT_W-1:0] count;
  } ljf_div_req_t;

endpackage

// ===== hw/rtl/lj_pair_force_accumulator_core.sv =====
// top level of the lennard-jones pair force accumulator
//
// Input channel (in_valid_i/in_ready_o/in_data_i): one beat per reference and
// neighbour pair. The front registers the beat, forms the minimum-image
// displacement and classifies it as self, zero distance or real pair; a
// two-entry queue holds classified pairs for the back end.
// Output channel (out_valid_o/out_ready_i/out_data_o): one beat after each
// pair marked last_neighbour, carrying the summed force and the two flags.
// Registers box_size, sigma and epsilon sit at byte addresses 0, 4 and 8 of
// the APB port; the user must write them only while the block is idle, and
// the block itself does not enforce this. Throughput: the back end handles
// one pair at a time on a shared 32x32 multiplier (one partial product a
// cycle) and a one-bit-a-cycle divider. A pair inside the cutoff runs up to
// two divisions, of 46 and 63 quotient bits; a pair beyond the cutoff skips
// them, a self or zero-distance pair uses neither unit. The back end starts
// a pair once its beat has passed the front's input register and the queue.
// Reset clears the sums, flags and queue and loads box 10.0, sigma and
// epsilon 1.0. When the receiver stalls, the result waits in the output
// register; the back end keeps working and only holds at the next last pair.
module lj_pair_force_accumulator_core
  import ljf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ljf_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ljf_out_t          out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [31:0] box_q, sigma_q, eps_q;
  logic        push, push_ready, head_valid, pop;
  ljf_pair_t   pair, head;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q   <= BOX_RESET;
      sigma_q <= SIGMA_RESET;
      eps_q   <= EPSILON_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_BOX:     box_q   <= pwdata;
        REG_SIGMA:   sigma_q <= pwdata;
        REG_EPSILON: eps_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BOX:     prdata = box_q;
      REG_SIGMA:   prdata = sigma_q;
      REG_EPSILON: prdata = eps_q;
      default:     prdata = '0;
    endcase
  end

  ljf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .box_i        (box_q),
    .push_o       (push),
    .push_ready_i (push_ready),
    .pair_o       (pair)
  );

  ljf_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .data_i       (pair),
    .valid_o      (head_valid),
    .pop_i        (pop),
    .data_o       (head)
  );

  ljf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .sigma_i      (sigma_q),
    .epsilon_i    (eps_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== hw/rtl/ljf_front.sv =====
// front end: input register, minimum-image displacement and pair classification
module ljf_front
  import ljf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ljf_in_t     in_data_i,
  input  logic [31:0] box_i,
  output logic        push_o,
  input  logic        push_ready_i,
  output ljf_pair_t   pair_o
);

  logic    hold_q, hold_d;
  ljf_in_t item_q;
  logic [2:0][POS_W-1:0] rp, np;
  logic [2:0][DISP_W-1:0] d;
  logic signed [DISP_W+1:0] v, v2, lb;

  assign in_ready_o = !hold_q || push_ready_i;
  assign push_o     = hold_q;

  // input beat register
  always_comb begin
    hold_d = hold_q;
    if (in_valid_i && in_ready_o) begin
      hold_d = 1'b1;
    end else if (push_ready_i) begin
      hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  // wrap each displacement by the box at most once
  assign rp = {item_q.ref_z, item_q.ref_y, item_q.ref_x};
  assign np = {item_q.nb_z, item_q.nb_y, item_q.nb_x};
  assign lb = $signed({3'b000, box_i});

  always_comb begin
    v  = '0;
    v2 = '0;
    for (int k = 0; k < 3; k++) begin
      v  = $signed({3'b000, rp[k]}) - $signed({3'b000, np[k]});
      v2 = v <<< 1;
      if (v2 >= lb) begin
        v = v - lb;
      end else if (v2 <= -lb) begin
        v = v + lb;
      end
      d[k] = v[DISP_W-1:0];
    end
  end

  // classify the pair
  always_comb begin
    pair_o.d    = d;
    pair_o.last = item_q.last_neighbour;
    if (item_q.is_self) begin
      pair_o.kind = KIND_SELF;
    end else if (d == '0) begin
      pair_o.kind = KIND_ZERO;
    end else begin
      pair_o.kind = KIND_PAIR;
    end
  end

endmodule

// ===== hw/rtl/ljf_fifo.sv =====
// short queue of classified pairs between front and back
module ljf_fifo
  import ljf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  output logic      push_ready_o,
  input  ljf_pair_t data_i,
  output logic      valid_o,
  input  logic      pop_i,
  output ljf_pair_t data_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

  ljf_pair_t           mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]      cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign push_ready_o = cnt_q != (PTR_W+1)'(FIFO_DEPTH);
  assign valid_o      = cnt_q != '0;
  assign data_o       = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && valid_o;

  // pointer update with wrap at the depth
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/ljf_mul.sv =====
// iterative multiplier: one 32x32 partial product per cycle into a wide accumulator
module ljf_mul
  import ljf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ljf_mul_req_t     req_i,
  output logic             done_o,
  output logic [ACC_W-1:0] acc_o
);

  logic [MA_W-1:0]  a_q;
  logic [MB_W-1:0]  b_q;
  logic [1:0]       i_q, a_last_q;
  logic             j_q, b_last_q;
  logic             busy_q, done_q;
  logic [ACC_W-1:0] acc_q;
  logic [63:0]      pp;
  logic [2:0]       k;
  logic [ACC_W-1:0] pp_sh;

  assign done_o = done_q;
  assign acc_o  = acc_q;

  // partial product placed at its limb offset
  assign pp    = a_q[{i_q, 5'b00000} +: 32] * b_q[{j_q, 5'b00000} +: 32];
  assign k     = {1'b0, i_q} + {2'b00, j_q};
  assign pp_sh = ACC_W'(pp) << {k, 5'b00000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
      j_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        i_q    <= '0;
        j_q    <= 1'b0;
      end else if (busy_q) begin
        if (j_q == b_last_q) begin
          j_q <= 1'b0;
          if (i_q == a_last_q) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end else begin
          j_q <= 1'b1;
        end
      end
    end
  end

  // operands and accumulator
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q      <= req_i.a;
      b_q      <= req_i.b;
      a_last_q <= req_i.a_last;
      b_last_q <= req_i.b_last;
      if (!req_i.keep) begin
        acc_q <= '0;
      end
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
    end
  end

endmodule

// ===== hw/rtl/ljf_div.sv =====
// restoring divider: one quotient bit per cycle
module ljf_div
  import ljf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ljf_div_req_t     req_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o
);

  logic [R2_W-1:0]  rem_q, dvs_q;
  logic [QUO_W-1:0] bits_q, quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [R2_W:0]    trial;
  logic [R2_W+1:0]  diff;

  assign done_o = done_q;
  assign quo_o  = quo_q;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_q, bits_q[QUO_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.count;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem_init;
      dvs_q  <= req_i.divisor;
      bits_q <= req_i.bits;
      quo_q  <= '0;
    end else if (busy_q) begin
      bits_q <= bits_q << 1;
      if (!diff[R2_W+1]) begin
        rem_q <= diff[R2_W-1:0];
        quo_q <= {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[R2_W-1:0];
        quo_q <= {quo_q[QUO_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hw/rtl/ljf_back.sv =====
// back end: sequencer over the shared multiplier and divider, running sums, result register
module ljf_back
  import ljf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  ljf_pair_t   head_i,
  output logic        pop_o,
  input  logic [31:0] sigma_i,
  input  logic [31:0] epsilon_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ljf_out_t    out_data_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_R2   = 4'd1;
  localparam logic [3:0] ST_SIG  = 4'd2;
  localparam logic [3:0] ST_CUT  = 4'd3;
  localparam logic [3:0] ST_DQ   = 4'd4;
  localparam logic [3:0] ST_Q2   = 4'd5;
  localparam logic [3:0] ST_S6   = 4'd6;
  localparam logic [3:0] ST_T    = 4'd7;
  localparam logic [3:0] ST_PM   = 4'd8;
  localparam logic [3:0] ST_Z    = 4'd9;
  localparam logic [3:0] ST_ZC   = 4'd10;
  localparam logic [3:0] ST_DM   = 4'd11;
  localparam logic [3:0] ST_CON  = 4'd12;
  localparam logic [3:0] ST_ACC  = 4'd13;
  localparam logic [3:0] ST_FIN  = 4'd14;

  logic [3:0]  state_q, state_d;
  logic [1:0]  comp_q, comp_d;
  logic        sat_q, sat_d, neg_q, neg_d;
  logic        zflag_q, zflag_d, oflag_q, oflag_d;
  logic signed [FORCE_W-1:0] sum_q [3];
  logic signed [FORCE_W-1:0] sum_d [3];
  logic        out_valid_q, out_valid_d;
  ljf_out_t    out_q, out_d;

  logic [R2_W-1:0]     r2_q, r2_d;
  logic [63:0]         s_q, s_d;
  logic [Q_LIMIT-1:0]  q_q, q_d;
  logic [61:0]         s6_q, s6_d;
  logic [127:0]        z_q, z_d;
  logic [M_W-1:0]      m_q, m_d;

  ljf_mul_req_t     mreq;
  ljf_div_req_t     dreq;
  logic             mdone, ddone;
  logic [ACC_W-1:0] acc;
  logic [QUO_W-1:0] quo;

  logic [2:0][31:0]       mag;
  logic [DISP_W-1:0]      negd;
  logic [69:0]            lim, r2x4;
  logic [62:0]            two, tval;
  logic [36:0]            e24;
  logic [127:0]           zhi;
  logic [FORCE_W:0]       vsum;
  logic [M_FRAC+30:0]     pmag;
  logic                   sub;

  ljf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .done_o (mdone),
    .acc_o  (acc)
  );

  ljf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .done_o (ddone),
    .quo_o  (quo)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // displacement magnitudes
  always_comb begin
    negd = '0;
    for (int k = 0; k < 3; k++) begin
      negd   = -head_i.d[k];
      mag[k] = head_i.d[k][DISP_W-1] ? negd[31:0] : head_i.d[k][31:0];
    end
  end

  // cutoff, sign term and scaled epsilon
  assign lim  = (70'(s_q) << 4) + (70'(s_q) << 3) + 70'(s_q);
  assign r2x4 = {r2_q, 2'b00};
  assign two  = {s6_q, 1'b0};
  assign e24  = (37'(epsilon_i) << 4) + (37'(epsilon_i) << 3);
  assign zhi  = z_q >> M_LIM_SHIFT;
  assign pmag = acc[M_FRAC +: (M_FRAC+31)];
  assign sub  = neg_q ^ head_i.d[comp_q][DISP_W-1];
  assign vsum = sub ? {sum_q[comp_q][FORCE_W-1], sum_q[comp_q]} - (FORCE_W+1)'(pmag)
                    : {sum_q[comp_q][FORCE_W-1], sum_q[comp_q]} + (FORCE_W+1)'(pmag);

  // sequencer
  always_comb begin
    state_d     = state_q;
    comp_d      = comp_q;
    sat_d       = sat_q;
    neg_d       = neg_q;
    zflag_d     = zflag_q;
    oflag_d     = oflag_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    r2_d        = r2_q;
    s_d         = s_q;
    q_d         = q_q;
    s6_d        = s6_q;
    z_d         = z_q;
    m_d         = m_q;
    pop_o       = 1'b0;
    mreq        = '0;
    dreq        = '0;
    dreq.divisor = r2_q;
    tval        = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          case (head_i.kind)
            KIND_PAIR: begin
              comp_d      = '0;
              sat_d       = 1'b0;
              neg_d       = 1'b0;
              mreq.start  = 1'b1;
              mreq.a      = MA_W'(mag[0]);
              mreq.b      = MB_W'(mag[0]);
              state_d     = ST_R2;
            end
            KIND_ZERO: begin
              zflag_d = 1'b1;
              state_d = ST_FIN;
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end
      // sum of squared components
      ST_R2: begin
        if (mdone) begin
          if (comp_q == 2'd2) begin
            r2_d       = acc[R2_W-1:0];
            mreq.start = 1'b1;
            mreq.a     = MA_W'(sigma_i);
            mreq.b     = MB_W'(sigma_i);
            state_d    = ST_SIG;
          end else begin
            comp_d     = comp_q + 1'b1;
            mreq.start = 1'b1;
            mreq.keep  = 1'b1;
            mreq.a     = MA_W'(mag[comp_q + 1'b1]);
            mreq.b     = MB_W'(mag[comp_q + 1'b1]);
          end
        end
      end
      ST_SIG: begin
        if (mdone) begin
          s_d     = acc[63:0];
          state_d = ST_CUT;
        end
      end
      // cutoff test, then sigma^2/r^2
      ST_CUT: begin
        comp_d = '0;
        if (lim < r2x4) begin
          state_d = ST_FIN;
        end else if (R2_W'(s_q >> Q_SHIFT) >= r2_q) begin
          sat_d   = 1'b1;
          state_d = ST_CON;
        end else begin
          dreq.start    = 1'b1;
          dreq.rem_init = R2_W'(s_q >> Q_SHIFT);
          dreq.bits     = {s_q[Q_SHIFT-1:0], (QUO_W-Q_SHIFT)'(0)};
          dreq.count    = CNT_W'(Q_LIMIT);
          state_d       = ST_DQ;
        end
      end
      ST_DQ: begin
        if (ddone) begin
          q_d        = quo[Q_LIMIT-1:0];
          mreq.start = 1'b1;
          mreq.a     = MA_W'(quo[Q_LIMIT-1:0]);
          mreq.b     = MB_W'(quo[Q_LIMIT-1:0]);
          mreq.a_last = 2'd1;
          mreq.b_last = 1'b1;
          state_d    = ST_Q2;
        end
      end
      ST_Q2: begin
        if (mdone) begin
          mreq.start  = 1'b1;
          mreq.a      = MA_W'(acc[Q_FRAC +: 60]);
          mreq.b      = MB_W'(q_q);
          mreq.a_last = 2'd1;
          mreq.b_last = 1'b1;
          state_d     = ST_S6;
        end
      end
      ST_S6: begin
        if (mdone) begin
          s6_d    = acc[(2*Q_FRAC-S6_FRAC) +: 62];
          state_d = ST_T;
        end
      end
      // 2*s6 - 1 with its sign apart
      ST_T: begin
        if (two >= (63'(1) << S6_FRAC)) begin
          tval = two - (63'(1) << S6_FRAC);
        end else begin
          tval  = (63'(1) << S6_FRAC) - two;
          neg_d = 1'b1;
        end
        mreq.start  = 1'b1;
        mreq.a      = MA_W'(s6_q);
        mreq.b      = MB_W'(tval);
        mreq.a_last = 2'd1;
        mreq.b_last = 1'b1;
        state_d     = ST_PM;
      end
      ST_PM: begin
        if (mdone) begin
          mreq.start  = 1'b1;
          mreq.a      = MA_W'(acc[S6_FRAC +: 105]);
          mreq.b      = MB_W'(e24);
          mreq.a_last = 2'd3;
          mreq.b_last = 1'b1;
          state_d     = ST_Z;
        end
      end
      ST_Z: begin
        if (mdone) begin
          comp_d = '0;
          if (acc[ACC_W-1:128] != '0) begin
            sat_d   = 1'b1;
            state_d = ST_CON;
          end else begin
            z_d     = acc[127:0];
            state_d = ST_ZC;
          end
        end
      end
      // force magnitude over r^2
      ST_ZC: begin
        if (zhi >= 128'(r2_q)) begin
          sat_d   = 1'b1;
          state_d = ST_CON;
        end else begin
          dreq.start    = 1'b1;
          dreq.rem_init = zhi[R2_W-1:0];
          dreq.bits     = {z_q[M_LIM_SHIFT-1:0], SCALE_SHIFT'(0)};
          dreq.count    = CNT_W'(M_W);
          state_d       = ST_DM;
        end
      end
      ST_DM: begin
        if (ddone) begin
          m_d     = quo[M_W-1:0];
          state_d = ST_CON;
        end
      end
      // per-component contribution
      ST_CON: begin
        if (head_i.d[comp_q] == '0 || sat_q) begin
          if (head_i.d[comp_q] != '0) begin
            oflag_d = 1'b1;
          end
          if (comp_q == 2'd2) begin
            state_d = ST_FIN;
          end else begin
            comp_d = comp_q + 1'b1;
          end
        end else begin
          mreq.start  = 1'b1;
          mreq.a      = MA_W'(m_q);
          mreq.b      = MB_W'(mag[comp_q]);
          mreq.a_last = 2'd1;
          state_d     = ST_ACC;
        end
      end
      ST_ACC: begin
        if (mdone) begin
          if (acc[ACC_W-1:FORCE_W+M_FRAC-1] != '0) begin
            oflag_d = 1'b1;
          end else if (vsum[FORCE_W] != vsum[FORCE_W-1]) begin
            oflag_d = 1'b1;
          end else begin
            sum_d[comp_q] = vsum[FORCE_W-1:0];
          end
          if (comp_q == 2'd2) begin
            state_d = ST_FIN;
          end else begin
            comp_d  = comp_q + 1'b1;
            state_d = ST_CON;
          end
        end
      end
      // retire the item, emit on the last neighbour
      ST_FIN: begin
        if (!head_i.last) begin
          pop_o   = 1'b1;
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          out_valid_d              = 1'b1;
          out_d.force_x            = oflag_q ? '0 : sum_q[0];
          out_d.force_y            = oflag_q ? '0 : sum_q[1];
          out_d.force_z            = oflag_q ? '0 : sum_q[2];
          out_d.zero_distance_seen = zflag_q;
          out_d.overflow_seen      = oflag_q;
          sum_d[0] = '0;
          sum_d[1] = '0;
          sum_d[2] = '0;
          zflag_d  = 1'b0;
          oflag_d  = 1'b0;
          pop_o    = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      comp_q      <= '0;
      sat_q       <= 1'b0;
      neg_q       <= 1'b0;
      zflag_q     <= 1'b0;
      oflag_q     <= 1'b0;
      sum_q[0]    <= '0;
      sum_q[1]    <= '0;
      sum_q[2]    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      comp_q      <= comp_d;
      sat_q       <= sat_d;
      neg_q       <= neg_d;
      zflag_q     <= zflag_d;
      oflag_q     <= oflag_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    r2_q  <= r2_d;
    s_q   <= s_d;
    q_q   <= q_d;
    s6_q  <= s6_d;
    z_q   <= z_d;
    m_q   <= m_d;
  end

endmodule

// ===== tb/sv/tb.sv =====
// testbench for the lennard-jones pair force accumulator core
`timescale 1ns / 1ps

module tb;
  import ljf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned DRAIN_CYCLES = 1200;
  localparam int unsigned LONG_HOLD = 3000;
  localparam logic [31:0] FULL = 32'hFFFF_FFFF;

  // force predictor with its own register copy, sums and expected results
  class force_scoreboard;
    logic [31:0] box, sig, eps;
    longint acc [3];
    bit zero_f, ovf_f;
    ljf_out_t want_q [$];
    int errors;

    function void clear();
      box = BOX_RESET;
      sig = SIGMA_RESET;
      eps = EPSILON_RESET;
      acc = '{0, 0, 0};
      zero_f = 0;
      ovf_f = 0;
      want_q.delete();
      errors = 0;
    endfunction

    task report(string what, longint got, longint exp);
      errors++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
    endtask

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_BOX:     box = val;
        REG_SIGMA:   sig = val;
        REG_EPSILON: eps = val;
        default: ;
      endcase
    endfunction

    // add one component's share of the pair force to its sum
    function void add_share(int k, bit sat, bit neg, logic [63:0] m, longint d);
      logic [127:0] mag, prod;
      longint v;
      if (d == 0) return;
      if (sat) begin
        ovf_f = 1;
        return;
      end
      mag = (d < 0) ? 128'(-d) : 128'(d);
      prod = (128'(m) * mag) >> M_FRAC;
      if (prod > 128'h7FFF_FFFF_FFFF) begin
        ovf_f = 1;
        return;
      end
      v = (neg != (d < 0)) ? acc[k] - longint'(prod[63:0]) : acc[k] + longint'(prod[63:0]);
      if (v > 64'sh7FFF_FFFF_FFFF || v < -64'sh8000_0000_0000) begin
        ovf_f = 1;
        return;
      end
      acc[k] = v;
    endfunction

    // minimum image, cutoff and lennard-jones multiplier for one pair
    function void pair_force(ljf_in_t it);
      longint d [3];
      longint lb, v;
      logic [255:0] r2, s, q, q2, s6, two, t, pm, z, zq, zr, mag;
      logic [63:0] m;
      logic [31:0] rp [3];
      logic [31:0] np [3];
      bit sat, neg;
      rp = '{it.ref_x, it.ref_y, it.ref_z};
      np = '{it.nb_x, it.nb_y, it.nb_z};
      lb = longint'(box);
      r2 = 0;
      sat = 0;
      neg = 0;
      m = 0;
      for (int i = 0; i < 3; i++) begin
        v = longint'(rp[i]) - longint'(np[i]);
        if (2 * v >= lb) v -= lb;
        else if (2 * v <= -lb) v += lb;
        d[i] = v;
        mag = (v < 0) ? 256'(-v) : 256'(v);
        r2 += mag * mag;
      end
      if (r2 == 0) begin
        zero_f = 1;
        return;
      end
      s = 256'(sig) * 256'(sig);
      if (s * 25 < (r2 << 2)) return;
      q = (s << Q_FRAC) / r2;
      if (q >= (256'(1) << Q_LIMIT)) sat = 1;
      else begin
        q2 = (q * q) >> Q_FRAC;
        s6 = (q2 * q) >> (2 * Q_FRAC - S6_FRAC);
        two = s6 << 1;
        if (two >= (256'(1) << S6_FRAC)) t = two - (256'(1) << S6_FRAC);
        else begin
          t = (256'(1) << S6_FRAC) - two;
          neg = 1;
        end
        pm = (s6 * t) >> S6_FRAC;
        z = pm * (256'(eps) * 24);
        if (z >= (256'(1) << 128)) sat = 1;
        else begin
          zq = z / r2;
          zr = z % r2;
          if (zq >= (256'(1) << (63 - SCALE_SHIFT))) sat = 1;
          else m = 64'((zq << SCALE_SHIFT) + ((zr << SCALE_SHIFT) / r2));
        end
      end
      for (int i = 0; i < 3; i++) add_share(i, sat, neg, m, d[i]);
    endfunction

    // accepted input beat
    function void note_pair(ljf_in_t it);
      ljf_out_t o;
      if (!it.is_self) pair_force(it);
      if (!it.last_neighbour) return;
      o.force_x = ovf_f ? '0 : acc[0][FORCE_W-1:0];
      o.force_y = ovf_f ? '0 : acc[1][FORCE_W-1:0];
      o.force_z = ovf_f ? '0 : acc[2][FORCE_W-1:0];
      o.zero_distance_seen = zero_f;
      o.overflow_seen = ovf_f;
      want_q.push_back(o);
      acc = '{0, 0, 0};
      zero_f = 0;
      ovf_f = 0;
    endfunction

    // accepted output beat
    task check_force(ljf_out_t got);
      ljf_out_t w;
      if (want_q.size() == 0) begin
        report("unexpected result beat", 0, 0);
        return;
      end
      w = want_q.pop_front();
      if (got.force_x !== w.force_x) report("force_x", got.force_x, w.force_x);
      if (got.force_y !== w.force_y) report("force_y", got.force_y, w.force_y);
      if (got.force_z !== w.force_z) report("force_z", got.force_z, w.force_z);
      if (got.zero_distance_seen !== w.zero_distance_seen)
        report("zero_distance_seen", got.zero_distance_seen, w.zero_distance_seen);
      if (got.overflow_seen !== w.overflow_seen)
        report("overflow_seen", got.overflow_seen, w.overflow_seen);
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  ljf_in_t in_data_i;
  ljf_out_t out_data_o;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  force_scoreboard sb = new();
  int unsigned cycles;
  bit no_gaps, hold_req, rst_done;

  lj_pair_force_accumulator_core uut (.*);

  always #4 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** lj_pair_force_accumulator_core: FAILED **");
      $finish;
    end
  end

  // result beat check
  always @(posedge clk_i)
    if (rst_done && out_valid_o && out_ready_i) sb.check_force(out_data_o);

  // receiver with random stalls and one long hold-off
  initial begin
    int hold;
    out_ready_i <= 0;
    wait (rst_done);
    forever begin
      if (hold_req) begin
        hold = LONG_HOLD;
        hold_req = 0;
      end else hold = no_gaps ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_ready_i <= 0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task send_pair(ljf_in_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pair(it);
  endtask

  task write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // let the pipe empty before touching registers
  task settle();
    in_valid_i <= 0;
    wait (sb.want_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task set_regs(logic [31:0] b, logic [31:0] s, logic [31:0] e);
    settle();
    write_reg(REG_BOX, b);
    write_reg(REG_SIGMA, s);
    write_reg(REG_EPSILON, e);
  endtask

  function automatic ljf_in_t mk(logic [31:0] rx, ry, rz, nx, ny, nz, bit slf, bit lst);
    ljf_in_t it;
    it = '{rx, ry, rz, nx, ny, nz, slf, lst};
    return it;
  endfunction

  // neighbour placed within a few sigma of a random reference
  function automatic ljf_in_t near_pair(bit lst);
    ljf_in_t it;
    logic [31:0] span, p;
    logic [31:0] off [3];
    span = (sb.sig > 32'h5555_5555) ? FULL : sb.sig * 3;
    for (int i = 0; i < 3; i++) begin
      off[i] = $urandom_range(0, span);
      if ($urandom_range(0, 1)) off[i] = -off[i];
      if ($urandom_range(0, 3) == 0) off[i] = 0;
    end
    p = $urandom;
    it = mk($urandom % sb.box, $urandom % sb.box, p % sb.box, 0, 0, 0, 0, lst);
    it.nb_x = it.ref_x - off[0];
    it.nb_y = it.ref_y - off[1];
    it.nb_z = it.ref_z - off[2];
    return it;
  endfunction

  // groups of neighbours ending with the last one, plus noise
  task random_items(int n);
    int cnt, len, kind;
    ljf_in_t it;
    cnt = 0;
    while (cnt < n) begin
      len = $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) no_gaps = ~no_gaps;
      for (int j = 0; j < len; j++) begin
        kind = $urandom_range(0, 19);
        if (kind < 14) it = near_pair(j == len - 1);
        else if (kind < 16) begin
          it = near_pair(j == len - 1);
          it.is_self = 1;
        end else if (kind < 17) begin
          it = near_pair(j == len - 1);
          it.nb_x = it.ref_x;
          it.nb_y = it.ref_y;
          it.nb_z = it.ref_z;
        end else begin
          it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 2'b00};
          it.is_self = ($urandom_range(0, 7) == 0);
          it.last_neighbour = (j == len - 1);
        end
        send_pair(it);
        cnt++;
      end
    end
  endtask

  initial begin
    sb.clear();
    rst_ni = 0;
    in_valid_i = 0;
    in_data_i = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    cycles = 0;
    no_gaps = 0;
    hold_req = 0;
    rst_done = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    rst_done = 1;

    // directed: default registers
    send_pair(mk(0, 0, 0, FULL, FULL, FULL, 0, 1));
    send_pair(mk(FULL, FULL, FULL, 0, 0, 0, 0, 1));
    send_pair(mk(32'h10000, 0, 0, 32'h10000, 0, 0, 1, 1));
    send_pair(mk(32'h20000, 32'h20000, 32'h20000, 32'h20000, 32'h20000, 32'h20000, 0, 1));
    send_pair(mk(32'h20000, 0, 0, 32'h31000, 0, 0, 0, 0));
    send_pair(mk(32'h20000, 0, 0, 32'h0E000, 0, 0, 0, 1));
    send_pair(mk(32'h20000, 0, 0, 32'h1F000, 0, 0, 0, 0));
    send_pair(mk(0, 32'h20000, 0, 0, 32'h1F000, 0, 0, 1));
    send_pair(mk(32'h20000, 32'h20000, 0, 32'h20001, 32'h20000, 0, 0, 1));
    send_pair(mk(32'h10000, 0, 0, 32'h90000, 0, 0, 0, 1));
    send_pair(mk(0, 0, 32'h10000, 0, 0, 32'h60000, 0, 1));
    send_pair(mk(0, 0, 0, 32'h30000, 0, 0, 0, 1));
    send_pair(mk(32'hC0000, 0, 0, 32'h1000, 0, 0, 0, 1));
    send_pair(mk(32'h50000, 32'h50000, 32'h50000, 32'h5C000, 32'h5C000, 32'h5C000, 0, 0));
    send_pair(mk(0, 0, 0, 0, 0, 0, 1, 0));
    send_pair(mk(1, 1, 1, 1, 1, 1, 0, 1));

    // directed: register extremes
    set_regs(FULL, 32'h10000, FULL);
    send_pair(mk(0, 0, 0, 32'h10000, 0, 0, 0, 1));
    send_pair(mk(0, 0, 0, 32'hC000, 32'h4000, 0, 0, 1));
    send_pair(mk(FULL, 0, 0, 0, 0, 0, 0, 1));
    set_regs(1, FULL, 1);
    send_pair(mk(FULL, FULL, FULL, 0, 0, 0, 0, 1));
    send_pair(mk(32'h8000_0000, 0, 0, 0, 0, 0, 0, 1));
    set_regs(FULL, 1, 32'h10000);
    send_pair(mk(0, 0, 0, 1, 0, 0, 0, 1));
    send_pair(mk(0, 0, 0, 2, 1, 1, 0, 1));

    // random phases over several settings, one with a long receiver hold-off
    set_regs(BOX_RESET, SIGMA_RESET, EPSILON_RESET);
    hold_req = 1;
    random_items(600);
    set_regs(32'h0100_0000, 32'h0008_0000, 32'h0002_8000);
    random_items(300);
    set_regs(FULL, FULL, FULL);
    random_items(200);
    set_regs(32'h0004_0000, 32'h0000_4000, 32'h0000_0100);
    random_items(300);
    set_regs(1, 1, 1);
    random_items(100);
    set_regs(32'h00A0_0000, 32'h0001_8000, 32'h0064_0000);
    random_items(200);

    settle();
    if (sb.want_q.size() != 0) sb.report("results never delivered", sb.want_q.size(), 0);
    if (sb.errors == 0) $display("** lj_pair_force_accumulator_core: PASSED **");
    else $display("** lj_pair_force_accumulator_core: FAILED **");
    $finish;
  end

endmodule
